>>> design/scs_pkg.sv
// Package for the stable counting sort block: beat structs, state enum,
// controller/datapath command and status structs. No dependencies.
package scs_pkg;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FRAC = 2'd1;
  localparam logic [1:0] STATUS_SPAN = 2'd2;

  typedef struct packed {
    logic [15:0]        row_index;
    logic signed [31:0] key;
    logic               is_missing;
    logic               is_fractional;
    logic               last_item;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] sorted_row;
    logic [1:0]  status;
    logic        last_result;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_CLEAR,
    ST_HIST,
    ST_HIST_WB,
    ST_PREFIX,
    ST_SCATTER,
    ST_SCATTER_WB,
    ST_EMIT,
    ST_FAIL
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_step;
    logic hist_start;
    logic hist_step;
    logic hist_wb;
    logic pre_start;
    logic pre_step;
    logic scat_start;
    logic scat_step;
    logic scat_wb;
    logic emit_start;
    logic emit_step;
    logic fail;
    logic batch_clear;
  } cmd_t;

  typedef struct packed {
    logic bad_frac;
    logic bad_span;
    logic any_valid;
    logic last_seen;
    logic clr_done;
    logic item_done;
    logic pre_done;
    logic emit_done;
    logic empty;
  } sts_t;

endpackage

>>> design/scs_ctrl.sv
// Controller state machine for the stable counting sort block.
// Depends on scs_pkg.
module scs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  scs_pkg::sts_t sts,
  output logic          busy,
  output scs_pkg::cmd_t cmd
);

  scs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scs_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scs_pkg::ST_LOAD: begin
        if (start && sts.last_seen) state_nxt = scs_pkg::ST_CHECK;
      end
      scs_pkg::ST_CHECK: begin
        if (sts.bad_frac || sts.bad_span) state_nxt = scs_pkg::ST_FAIL;
        else if (sts.empty) state_nxt = scs_pkg::ST_LOAD;
        else if (!sts.any_valid) state_nxt = scs_pkg::ST_EMIT;
        else state_nxt = scs_pkg::ST_CLEAR;
      end
      scs_pkg::ST_CLEAR: begin
        if (sts.clr_done) state_nxt = scs_pkg::ST_HIST;
      end
      scs_pkg::ST_HIST:    state_nxt = scs_pkg::ST_HIST_WB;
      scs_pkg::ST_HIST_WB: begin
        state_nxt = sts.item_done ? scs_pkg::ST_PREFIX : scs_pkg::ST_HIST;
      end
      scs_pkg::ST_PREFIX: begin
        if (sts.pre_done) state_nxt = scs_pkg::ST_SCATTER;
      end
      scs_pkg::ST_SCATTER:    state_nxt = scs_pkg::ST_SCATTER_WB;
      scs_pkg::ST_SCATTER_WB: begin
        state_nxt = sts.item_done ? scs_pkg::ST_EMIT : scs_pkg::ST_SCATTER;
      end
      scs_pkg::ST_EMIT: begin
        if (sts.emit_done) state_nxt = scs_pkg::ST_LOAD;
      end
      scs_pkg::ST_FAIL: state_nxt = scs_pkg::ST_LOAD;
      default:          state_nxt = scs_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != scs_pkg::ST_LOAD);
    unique case (state_r)
      scs_pkg::ST_LOAD: begin
        cmd.load = start;
      end
      scs_pkg::ST_CHECK: begin
        cmd.clr_start  = 1'b1;
        cmd.emit_start = 1'b1;
        cmd.batch_clear = sts.empty;
      end
      scs_pkg::ST_CLEAR: begin
        cmd.clr_step   = 1'b1;
        cmd.hist_start = sts.clr_done;
      end
      scs_pkg::ST_HIST:    cmd.hist_step = 1'b1;
      scs_pkg::ST_HIST_WB: begin
        cmd.hist_wb   = 1'b1;
        cmd.pre_start = sts.item_done;
      end
      scs_pkg::ST_PREFIX: begin
        cmd.pre_step   = 1'b1;
        cmd.scat_start = sts.pre_done;
      end
      scs_pkg::ST_SCATTER:    cmd.scat_step = 1'b1;
      scs_pkg::ST_SCATTER_WB: cmd.scat_wb = 1'b1;
      scs_pkg::ST_EMIT: begin
        cmd.emit_step   = 1'b1;
        cmd.batch_clear = sts.emit_done;
      end
      scs_pkg::ST_FAIL: begin
        cmd.fail        = 1'b1;
        cmd.batch_clear = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> design/scs_dp.sv
// Datapath for the stable counting sort block: item store, bucket memory,
// sorted store, min/max tracking and the emit register. Depends on scs_pkg.
module scs_dp #(
  parameter int MAX_ITEMS   = 64,
  parameter int MAX_BUCKETS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  scs_pkg::in_beat_t  in_beat,
  input  scs_pkg::cmd_t      cmd,
  output scs_pkg::sts_t      sts,
  output logic               out_valid,
  output scs_pkg::out_beat_t out_beat
);

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int BW = $clog2(MAX_BUCKETS + 1);

  logic [15:0] row_mem [MAX_ITEMS];
  logic [31:0] key_mem [MAX_ITEMS];
  logic        miss_mem [MAX_ITEMS];
  logic [CW-1:0] cnt_mem [MAX_BUCKETS+1];
  logic [15:0] srt_mem [MAX_ITEMS];

  logic [CW-1:0]      item_count_r;
  logic signed [31:0] key_min_r, key_max_r;
  logic               seen_valid_r, seen_fraction_r;
  logic [BW-1:0]      span_r;
  logic [CW-1:0]      idx_r;
  logic [BW-1:0]      bkt_r;
  logic [CW-1:0]      run_r;
  logic [15:0]        row_q_r;
  logic [31:0]        key_q_r;
  logic               miss_q_r;
  logic [CW-1:0]      cnt_q_r;
  logic [BW-1:0]      cb_r;
  logic [32:0]        diff;
  logic [BW-1:0]      item_bkt;
  logic [BW-1:0]      bkt_r_rd;
  logic [BW-1:0]      cnt_rd;
  logic               out_valid_r;
  scs_pkg::out_beat_t out_beat_r;

  assign diff = {key_max_r[31], key_max_r} - {key_min_r[31], key_min_r};

  logic [32:0] kdiff;
  assign kdiff = {key_q_r[31], key_q_r} - {key_min_r[31], key_min_r};
  assign item_bkt = miss_q_r ? span_r : kdiff[BW-1:0];

  assign sts.bad_frac  = seen_fraction_r;
  assign sts.bad_span  = seen_valid_r && (diff >= 33'(MAX_BUCKETS));
  assign sts.any_valid = seen_valid_r;
  assign sts.last_seen = in_beat.last_item;
  assign sts.clr_done  = (bkt_r == span_r);
  assign sts.item_done = (idx_r == item_count_r);
  assign sts.pre_done  = (bkt_r == span_r);
  assign sts.emit_done = (idx_r + CW'(1) == item_count_r);
  assign sts.empty     = (item_count_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load && item_count_r < CW'(MAX_ITEMS)) begin
      row_mem[item_count_r[IW-1:0]]  <= in_beat.row_index;
      key_mem[item_count_r[IW-1:0]]  <= in_beat.key;
      miss_mem[item_count_r[IW-1:0]] <= in_beat.is_missing;
    end
    row_q_r  <= row_mem[idx_r[IW-1:0]];
    key_q_r  <= key_mem[idx_r[IW-1:0]];
    miss_q_r <= miss_mem[idx_r[IW-1:0]];
  end

  assign bkt_r_rd = cmd.pre_start ? '0 : (bkt_r + BW'(1));
  assign cnt_rd   = (cmd.pre_start || cmd.pre_step) ? bkt_r_rd : item_bkt;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      cnt_mem[bkt_r] <= '0;
    end else if (cmd.hist_wb) begin
      cnt_mem[cb_r] <= cnt_q_r + CW'(1);
    end else if (cmd.pre_step) begin
      cnt_mem[bkt_r] <= run_r;
    end else if (cmd.scat_wb) begin
      cnt_mem[cb_r] <= cnt_q_r + CW'(1);
    end
    if (cmd.hist_wb && cnt_rd == cb_r) begin
      cnt_q_r <= cnt_q_r + CW'(1);
    end else begin
      cnt_q_r <= cnt_mem[cnt_rd];
    end
    cb_r    <= item_bkt;
  end

  always_ff @(posedge clk) begin
    if (cmd.scat_wb) srt_mem[cnt_q_r[IW-1:0]] <= row_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r    <= '0;
      key_min_r       <= '0;
      key_max_r       <= '0;
      seen_valid_r    <= 1'b0;
      seen_fraction_r <= 1'b0;
      span_r          <= '0;
      idx_r           <= '0;
      bkt_r           <= '0;
      run_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cmd.load && item_count_r < CW'(MAX_ITEMS)) begin
        item_count_r <= item_count_r + CW'(1);
        if (!in_beat.is_missing) begin
          if (in_beat.is_fractional) seen_fraction_r <= 1'b1;
          if (!seen_valid_r || in_beat.key < key_min_r) key_min_r <= in_beat.key;
          if (!seen_valid_r || in_beat.key > key_max_r) key_max_r <= in_beat.key;
          seen_valid_r <= 1'b1;
        end
      end
      if (cmd.clr_start) begin
        span_r <= seen_valid_r ? BW'(diff + 33'd1) : '0;
        bkt_r  <= '0;
        idx_r  <= '0;
      end
      if (cmd.clr_step && !sts.clr_done) bkt_r <= bkt_r + BW'(1);
      if (cmd.hist_start) idx_r <= '0;
      if (cmd.hist_step || cmd.scat_step) idx_r <= idx_r + CW'(1);
      if (cmd.pre_start) begin
        bkt_r <= '0;
        run_r <= '0;
        idx_r <= '0;
      end
      if (cmd.pre_step) begin
        run_r <= run_r + cnt_q_r;
        bkt_r <= bkt_r + BW'(1);
      end
      if (cmd.scat_start) idx_r <= '0;
      if (cmd.scat_wb && sts.item_done) idx_r <= '0;
      if (cmd.emit_step) begin
        out_valid_r <= 1'b1;
        out_beat_r.sorted_row  <= seen_valid_r ? srt_mem[idx_r[IW-1:0]]
                                               : row_mem[idx_r[IW-1:0]];
        out_beat_r.status      <= scs_pkg::STATUS_OK;
        out_beat_r.last_result <= sts.emit_done;
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.fail) begin
        out_valid_r <= 1'b1;
        out_beat_r.sorted_row  <= '0;
        out_beat_r.status      <= seen_fraction_r ? scs_pkg::STATUS_FRAC
                                                  : scs_pkg::STATUS_SPAN;
        out_beat_r.last_result <= 1'b1;
      end
      if (cmd.batch_clear) begin
        item_count_r    <= '0;
        key_min_r       <= '0;
        key_max_r       <= '0;
        seen_valid_r    <= 1'b0;
        seen_fraction_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

>>> design/stable_counting_sort_with_missing.sv
// Stable counting sort of a row batch with a final bucket for missing keys.
// Beats load one per cycle while start is high. Then: a check, a clear of
// span+1 buckets, histogram read/write-back per item, prefix over span+1,
// scatter read/write-back per item, emit per item with registered beats; a
// failed batch gives one beat after check and fail. busy stays high until the
// final beat is issued. Synchronous active-low reset empties the batch.
module stable_counting_sort_with_missing #(
  parameter int MAX_ITEMS   = 64,
  parameter int MAX_BUCKETS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  scs_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  output scs_pkg::out_beat_t out_beat
);

  scs_pkg::cmd_t cmd;
  scs_pkg::sts_t sts;

  scs_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .busy (busy),
    .cmd  (cmd)
  );

  scs_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .MAX_BUCKETS(MAX_BUCKETS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_beat),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_beat (out_beat)
  );

endmodule
